// ===== sv/pstct_pkg.sv =====
// shared constants and types for the per-station traffic counter table
// no dependencies; used by the interfaces, the controller, the datapath and the top level
package pstct_pkg;

   localparam int TABLE_ENTRIES_DEF = 4096;

   localparam int ACT_W   = 2;
   localparam int IFX_W   = 16;
   localparam int MAC_W   = 48;
   localparam int LEN_W   = 16;
   localparam int KEY_W   = IFX_W + MAC_W;
   localparam int CNT_W   = 64;
   localparam int LIMIT_W = 13;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 13'd4096;

   // action codes; anything else only reads
   localparam logic [ACT_W-1:0] ACT_RX    = 2'd0;
   localparam logic [ACT_W-1:0] ACT_TX    = 2'd1;
   localparam logic [ACT_W-1:0] ACT_READ  = 2'd2;
   localparam logic [ACT_W-1:0] ACT_SPARE = 2'd3;

   typedef struct packed {
      logic [CNT_W-1:0] bytes_total;
      logic [CNT_W-1:0] packets_total;
      logic [CNT_W-1:0] rx_bytes;
      logic [CNT_W-1:0] rx_packets;
      logic [CNT_W-1:0] tx_bytes;
      logic [CNT_W-1:0] tx_packets;
   } counters_type;

   typedef struct packed {
      logic clear_wr;
      logic load;
      logic rd;
      logic step;
      logic commit;
   } dp_cmd_type;

   typedef struct packed {
      logic clear_done;
      logic hit;
      logic empty;
      logic exhausted;
      logic out_free;
   } dp_sts_type;

endpackage

// ===== sv/pstct_if.sv =====
// channel interfaces: frame request, counter response, limit register write
// depends on pstct_pkg for field widths
interface pstct_req_if;
   logic                           valid;
   logic                           ready;
   logic [pstct_pkg::ACT_W-1:0]    action;
   logic [pstct_pkg::IFX_W-1:0]    interface_index;
   logic [pstct_pkg::MAC_W-1:0]    station_mac;
   logic [pstct_pkg::LEN_W-1:0]    frame_length;
   logic                           header_complete;
   modport source (output valid, action, interface_index, station_mac, frame_length,
                   header_complete, input ready);
   modport sink (input valid, action, interface_index, station_mac, frame_length,
                 header_complete, output ready);
endinterface

interface pstct_rsp_if;
   logic                           valid;
   logic                           ready;
   logic                           found;
   logic                           table_full;
   logic [pstct_pkg::CNT_W-1:0]    bytes_total;
   logic [pstct_pkg::CNT_W-1:0]    packets_total;
   logic [pstct_pkg::CNT_W-1:0]    rx_bytes;
   logic [pstct_pkg::CNT_W-1:0]    rx_packets;
   logic [pstct_pkg::CNT_W-1:0]    tx_bytes;
   logic [pstct_pkg::CNT_W-1:0]    tx_packets;
   modport source (output valid, found, table_full, bytes_total, packets_total, rx_bytes,
                   rx_packets, tx_bytes, tx_packets, input ready);
   modport sink (input valid, found, table_full, bytes_total, packets_total, rx_bytes,
                 rx_packets, tx_bytes, tx_packets, output ready);
endinterface

interface pstct_csr_if;
   logic                           valid;
   logic                           ready;
   logic [pstct_pkg::LIMIT_W-1:0]  data;
   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

// ===== sv/pstct_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
module pstct_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== sv/pstct_ctrl.sv =====
// controller: clearing sweep, item intake and probe sequencing
// depends on pstct_pkg for the command and status structs
module pstct_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  pstct_pkg::dp_sts_type sts,
   output pstct_pkg::dp_cmd_type cmd
);

   typedef enum logic [3:0] {
      ST_CLEAR = 4'b0001,
      ST_IDLE  = 4'b0010,
      ST_READ  = 4'b0100,
      ST_CHECK = 4'b1000
   } ctrl_state_type;

   ctrl_state_type state_ff, state_in;
   logic           done;

   assign done = sts.hit | sts.empty | sts.exhausted;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_wr = 1'b1;
            if (sts.clear_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            cmd.rd   = 1'b1;
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (done) begin
               // hold here until the output register can take the beat
               if (sts.out_free) begin
                  cmd.commit = 1'b1;
                  state_in   = ST_IDLE;
               end
            end else begin
               cmd.step = 1'b1;
               state_in = ST_READ;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   a_commit_only_when_done: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> done && sts.out_free)
      else $error("commit without a finished probe");

   a_probe_follows_read: assert property (@(posedge clock) disable iff (reset)
      cmd.rd |=> (cmd.commit || cmd.step || !sts.out_free))
      else $error("probe result not handled after read");

   a_no_intake_while_clearing: assert property (@(posedge clock) disable iff (reset)
      cmd.clear_wr |-> !req_ready)
      else $error("request taken during clearing sweep");

endmodule

// ===== sv/pstct_dpath.sv =====
// datapath: key and counter rams, linear probe address, occupancy, output register
// depends on pstct_pkg, pstct_if and pstct_ram
module pstct_dpath #(
   parameter int TABLE_ENTRIES = pstct_pkg::TABLE_ENTRIES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  pstct_pkg::dp_cmd_type         cmd,
   output pstct_pkg::dp_sts_type         sts,
   input  logic [pstct_pkg::ACT_W-1:0]   req_action,
   input  logic [pstct_pkg::IFX_W-1:0]   req_interface_index,
   input  logic [pstct_pkg::MAC_W-1:0]   req_station_mac,
   input  logic [pstct_pkg::LEN_W-1:0]   req_frame_length,
   input  logic                          req_header_complete,
   pstct_csr_if.sink                     csr,
   pstct_rsp_if.source                   rsp
);

   localparam int AW = $clog2(TABLE_ENTRIES);
   localparam int OW = $clog2(TABLE_ENTRIES + 1);
   localparam int CW = (OW > pstct_pkg::LIMIT_W) ? OW : pstct_pkg::LIMIT_W;
   localparam int KW = pstct_pkg::KEY_W;
   localparam int RW = $bits(pstct_pkg::counters_type);
   localparam logic [AW-1:0] LAST_ADDR = AW'(TABLE_ENTRIES - 1);

   logic [KW-1:0]                   key_ff;
   logic [pstct_pkg::LEN_W-1:0]     len_ff;
   logic                            count_ff;
   logic                            is_rx_ff;
   logic [AW-1:0]                   addr_ff;
   logic [AW-1:0]                   probe_ff;
   logic [AW-1:0]                   clr_ff;
   logic [pstct_pkg::LIMIT_W-1:0]   limit_ff;
   logic [OW-1:0]                   occ_ff;
   logic                            rsp_valid_ff;
   logic                            found_ff;
   logic                            full_ff;
   pstct_pkg::counters_type         out_ff;

   logic [KW-1:0]                   key_in;
   logic [AW-1:0]                   fold;
   logic [AW:0]                     fold_ext;
   logic [AW-1:0]                   hash;
   logic                            key_we;
   logic [AW-1:0]                   key_waddr;
   logic [KW:0]                     key_wdata;
   logic [KW:0]                     key_rdata;
   logic                            cnt_we;
   logic [RW-1:0]                   cnt_rdata;
   pstct_pkg::counters_type         base;
   pstct_pkg::counters_type         upd;
   logic [pstct_pkg::CNT_W-1:0]     inc_len;
   logic [pstct_pkg::CNT_W-1:0]     inc_pkt;
   logic [CW-1:0]                   eff_limit;
   logic                            room;
   logic                            hit;
   logic                            insert;
   logic                            found;

   assign key_in = {req_interface_index, req_station_mac};

   // fold the key down to an address, then bring it below the table size
   always_comb begin
      fold = '0;
      for (int i = 0; i < KW; i++) begin
         fold[i % AW] = fold[i % AW] ^ key_in[i];
      end
   end
   assign fold_ext = {1'b0, fold};
   assign hash = (fold_ext >= (AW+1)'(TABLE_ENTRIES)) ?
                 AW'(fold_ext - (AW+1)'(TABLE_ENTRIES)) : fold;

   assign key_we    = cmd.clear_wr | (cmd.commit & insert);
   assign key_waddr = cmd.clear_wr ? clr_ff : addr_ff;
   assign key_wdata = cmd.clear_wr ? '0 : {1'b1, key_ff};

   pstct_ram #(.WIDTH(KW + 1), .DEPTH(TABLE_ENTRIES)) u_key_ram (
      .clock (clock),
      .we    (key_we),
      .waddr (key_waddr),
      .wdata (key_wdata),
      .re    (cmd.rd),
      .raddr (addr_ff),
      .rdata (key_rdata)
   );

   assign cnt_we = cmd.commit & count_ff & found;

   pstct_ram #(.WIDTH(RW), .DEPTH(TABLE_ENTRIES)) u_cnt_ram (
      .clock (clock),
      .we    (cnt_we),
      .waddr (addr_ff),
      .wdata (upd),
      .re    (cmd.rd),
      .raddr (addr_ff),
      .rdata (cnt_rdata)
   );

   assign hit = key_rdata[KW] && (key_rdata[KW-1:0] == key_ff);

   assign eff_limit = (CW'(limit_ff) > CW'(TABLE_ENTRIES)) ? CW'(TABLE_ENTRIES) : CW'(limit_ff);
   assign room      = CW'(occ_ff) < eff_limit;
   // an empty slot on the probe path means the key is absent: nothing is ever removed
   assign insert    = count_ff & ~hit & ~key_rdata[KW] & room;
   assign found     = hit | insert;

   assign inc_len = count_ff ? pstct_pkg::CNT_W'(len_ff) : '0;
   assign inc_pkt = count_ff ? pstct_pkg::CNT_W'(1) : '0;

   always_comb begin
      base = hit ? pstct_pkg::counters_type'(cnt_rdata) : '0;
      upd  = base;
      upd.bytes_total   = base.bytes_total + inc_len;
      upd.packets_total = base.packets_total + inc_pkt;
      if (is_rx_ff) begin
         upd.rx_bytes   = base.rx_bytes + inc_len;
         upd.rx_packets = base.rx_packets + inc_pkt;
      end else begin
         upd.tx_bytes   = base.tx_bytes + inc_len;
         upd.tx_packets = base.tx_packets + inc_pkt;
      end
   end

   assign sts.clear_done = (clr_ff == LAST_ADDR);
   assign sts.hit        = hit;
   assign sts.empty      = ~key_rdata[KW];
   assign sts.exhausted  = (probe_ff == LAST_ADDR);
   assign sts.out_free   = ~rsp_valid_ff | rsp.ready;

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         key_ff   <= key_in;
         len_ff   <= req_frame_length;
         count_ff <= req_header_complete &&
                     (req_action == pstct_pkg::ACT_RX || req_action == pstct_pkg::ACT_TX);
         is_rx_ff <= (req_action == pstct_pkg::ACT_RX);
         addr_ff  <= hash;
         probe_ff <= '0;
      end else if (cmd.step) begin
         addr_ff  <= (addr_ff == LAST_ADDR) ? '0 : addr_ff + AW'(1);
         probe_ff <= probe_ff + AW'(1);
      end
      if (cmd.commit) begin
         found_ff <= found;
         full_ff  <= count_ff & ~found;
         out_ff   <= found ? upd : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= '0;
         limit_ff     <= pstct_pkg::LIMIT_RESET;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.clear_wr) begin
            clr_ff <= clr_ff + AW'(1);
         end
         if (csr.valid) begin
            limit_ff <= csr.data;
         end
         if (cmd.commit && insert) begin
            occ_ff <= occ_ff + OW'(1);
         end
         if (cmd.commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign csr.ready         = 1'b1;
   assign rsp.valid         = rsp_valid_ff;
   assign rsp.found         = found_ff;
   assign rsp.table_full    = full_ff;
   assign rsp.bytes_total   = out_ff.bytes_total;
   assign rsp.packets_total = out_ff.packets_total;
   assign rsp.rx_bytes      = out_ff.rx_bytes;
   assign rsp.rx_packets    = out_ff.rx_packets;
   assign rsp.tx_bytes      = out_ff.tx_bytes;
   assign rsp.tx_packets    = out_ff.tx_packets;

   a_occ_bounded: assert property (@(posedge clock) disable iff (reset)
      CW'(occ_ff) <= CW'(TABLE_ENTRIES))
      else $error("occupancy above table size");

   a_insert_needs_room: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && insert) |-> room && !hit)
      else $error("insert past the entry limit");

   a_commit_shows_beat: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_valid_ff)
      else $error("committed item produced no response beat");

endmodule

// ===== sv/per_station_traffic_counter_table_top.sv =====
// per-station traffic counter table, top level
// depends on pstct_pkg, pstct_if, pstct_ctrl and pstct_dpath
//
// req_ch carries one frame beat: action, interface index, station mac, length and
// header-complete flag. the key {interface_index, station_mac} is hashed into a
// table of TABLE_ENTRIES slots and probed linearly until the key or an empty slot
// turns up, or all are probed. a count action on a complete header bumps the key's
// counters, inserting a zeroed entry when the key is new and the entry limit allows it.
// rsp_ch returns one beat per request with found, table_full and the six counters
// after the update. csr_ch writes the 13-bit entry limit; it is always ready, and the
// user must write it only while the block is idle: the block does not enforce this.
// each request passes through the idle, read and check states; a probe that finds
// neither the key nor an empty slot steps to the next slot and goes back to read. each
// probe costs one key/counter ram read and one compare. the controller is back in idle,
// ready for a new request, as soon as the response is registered.
// reset: the controller sweeps every slot of the key ram, one slot per cycle, with
// req_ch.ready low; occupancy goes to zero and the limit to 4096.
// a stalled rsp_ch keeps its beat in the output register; the block still takes
// the next request and holds that result until the register frees up.
module per_station_traffic_counter_table_top #(
   parameter int TABLE_ENTRIES = pstct_pkg::TABLE_ENTRIES_DEF
) (
   input  logic         clock,
   input  logic         reset,
   pstct_req_if.sink    req_ch,
   pstct_rsp_if.source  rsp_ch,
   pstct_csr_if.sink    csr_ch
);

   pstct_pkg::dp_cmd_type cmd;
   pstct_pkg::dp_sts_type sts;

   pstct_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   pstct_dpath #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_dpath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .sts                 (sts),
      .req_action          (req_ch.action),
      .req_interface_index (req_ch.interface_index),
      .req_station_mac     (req_ch.station_mac),
      .req_frame_length    (req_ch.frame_length),
      .req_header_complete (req_ch.header_complete),
      .csr                 (csr_ch),
      .rsp                 (rsp_ch)
   );

endmodule
